[design/ard_pkg.sv]
// Package for the accelerometer repetition detector.
// Holds the widths, the register index codes and the structs shared by the design files.
// No dependencies.
package ard_pkg;

  localparam int SampleBits = 16;
  localparam int ThrW       = 15;
  localparam int CountW     = 4;
  localparam int CycW       = 8;
  localparam int CfgIdxW    = 3;
  localparam int CfgDataW   = 15;

  localparam int SqW     = 2 * SampleBits;
  localparam int LimSqW  = 2 * ThrW;
  localparam int MagCmpW = (SqW > LimSqW) ? SqW : LimSqW;
  localparam int AbsCmpW = (SampleBits > ThrW) ? SampleBits : ThrW;
  localparam int ZCmpW   = AbsCmpW + 1;

  localparam logic [CountW-1:0] CountMax = '1;
  localparam logic [CycW-1:0]   CycMax   = '1;

  typedef enum logic [CfgIdxW-1:0] {
    RegZThresh        = 3'd0,
    RegMinMagnitude   = 3'd1,
    RegExtremeLimit   = 3'd2,
    RegConsistentCnt  = 3'd3,
    RegCooldownSmp    = 3'd4,
    RegTimeoutSmp     = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic [ThrW-1:0]   z_thresh;
    logic [ThrW-1:0]   min_magnitude;
    logic [ThrW-1:0]   extreme_limit;
    logic [CountW-1:0] consistent_count;
    logic [CycW-1:0]   cooldown_samples;
    logic [CycW-1:0]   timeout_samples;
  } ard_cfg_t;

  typedef struct packed {
    logic extreme;
    logic mag_ok;
    logic z_low;
    logic z_high;
  } ard_flags_t;

endpackage

[design/ard_feature.sv]
// Feature pipeline of the repetition detector: squares, magnitude sum and sample classification.
// Depends on ard_pkg.
module ard_feature import ard_pkg::*; (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  ard_cfg_t                     cfg_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [SampleBits-1:0] accel_x_i,
  input  logic signed [SampleBits-1:0] accel_y_i,
  input  logic signed [SampleBits-1:0] accel_z_i,
  output logic                         flags_valid_o,
  input  logic                         flags_ready_i,
  output ard_flags_t                   flags_o
);

  logic                  v0_q, v1_q, v2_q, v3_q;
  logic                  rdy0, rdy1, rdy2, rdy3;

  logic [SampleBits-1:0] x0_q, y0_q, z0_q;
  logic [SampleBits-1:0] ax, ay, az;
  logic [SqW-1:0]        sx1_q, sy1_q, sz1_q;
  logic [SampleBits-1:0] az1_q, z1_q;
  logic [SqW-1:0]        mag2_q;
  logic [SampleBits-1:0] az2_q, z2_q;
  logic [LimSqW-1:0]     lim2_q, min2_q;
  ard_flags_t            flags_d, flags_q;

  logic [MagCmpW-1:0]       mag_ext, lim2_ext, min2_ext;
  logic [AbsCmpW-1:0]       az_ext, lim_ext;
  logic signed [ZCmpW-1:0]  z_ext, thr_ext, thr_neg;

  assign rdy3 = !v3_q || flags_ready_i;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;
  assign rdy0 = !v0_q || rdy1;
  assign in_ready_o    = rdy0;
  assign flags_valid_o = v3_q;
  assign flags_o       = flags_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy0) v0_q <= in_valid_i;
      if (rdy1) v1_q <= v0_q;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
    end
  end

  assign ax = x0_q[SampleBits-1] ? (~x0_q + 1'b1) : x0_q;
  assign ay = y0_q[SampleBits-1] ? (~y0_q + 1'b1) : y0_q;
  assign az = z0_q[SampleBits-1] ? (~z0_q + 1'b1) : z0_q;

  // The configuration squares are registered, so they follow the registers in the cycle after.
  always_ff @(posedge clk_i) begin
    lim2_q <= LimSqW'(cfg_i.extreme_limit) * LimSqW'(cfg_i.extreme_limit);
    min2_q <= LimSqW'(cfg_i.min_magnitude) * LimSqW'(cfg_i.min_magnitude);
  end

  always_ff @(posedge clk_i) begin
    if (rdy0 && in_valid_i) begin
      x0_q <= accel_x_i;
      y0_q <= accel_y_i;
      z0_q <= accel_z_i;
    end
    if (rdy1 && v0_q) begin
      sx1_q <= SqW'(ax) * SqW'(ax);
      sy1_q <= SqW'(ay) * SqW'(ay);
      sz1_q <= SqW'(az) * SqW'(az);
      az1_q <= az;
      z1_q  <= z0_q;
    end
    if (rdy2 && v1_q) begin
      mag2_q <= sx1_q + sy1_q + sz1_q;
      az2_q  <= az1_q;
      z2_q   <= z1_q;
    end
    if (rdy3 && v2_q) begin
      flags_q <= flags_d;
    end
  end

  always_comb begin
    mag_ext  = MagCmpW'(mag2_q);
    lim2_ext = MagCmpW'(lim2_q);
    min2_ext = MagCmpW'(min2_q);
    az_ext   = AbsCmpW'(az2_q);
    lim_ext  = AbsCmpW'(cfg_i.extreme_limit);
    z_ext    = signed'({{(ZCmpW-SampleBits){z2_q[SampleBits-1]}}, z2_q});
    thr_ext  = signed'({{(ZCmpW-ThrW){1'b0}}, cfg_i.z_thresh});
    thr_neg  = -thr_ext;
    flags_d.extreme = (az_ext > lim_ext) || (mag_ext > lim2_ext);
    flags_d.mag_ok  = mag_ext > min2_ext;
    flags_d.z_low   = z_ext < thr_neg;
    flags_d.z_high  = z_ext > thr_ext;
  end

endmodule

[design/accel_rep_detector.sv]
// Top level of the accelerometer repetition detector: configuration registers, rep state, result.
// Depends on ard_pkg and ard_feature.
// Every accepted sample yields exactly one result. A sample is accepted in every cycle when the
// result side keeps up. The sample is registered, three stages square the axes, sum the
// magnitude and classify the sample, and the rep state is updated as the result register loads.
// The result register and the stage valid bits let the input keep taking samples while a
// finished result waits to be taken, until the stages are full.
// Configuration writes are always taken; they should only be made while no sample is in flight,
// since the later stages read the registers directly.
module accel_rep_detector import ard_pkg::*; (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [SampleBits-1:0] accel_x_i,
  input  logic signed [SampleBits-1:0] accel_y_i,
  input  logic signed [SampleBits-1:0] accel_z_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         rep_detected_o,
  output logic                         rep_in_progress_o,
  output logic                         sample_ignored_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [CfgIdxW-1:0]           cfg_index_i,
  input  logic [CfgDataW-1:0]          cfg_data_i
);

  ard_cfg_t          cfg_q;
  logic              flags_valid, flags_ready;
  ard_flags_t        flags;

  logic              in_rep_q, in_rep_d;
  logic [CountW-1:0] down_q, down_d, up_q, up_d, cnt_inc;
  logic [CycW-1:0]   cool_q, cool_d, timer_q, timer_d, timer_inc;
  logic              done;

  logic              out_valid_q;
  logic              det_q, det_d, prog_q, ign_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.z_thresh         <= ThrW'(77);
      cfg_q.min_magnitude    <= ThrW'(256);
      cfg_q.extreme_limit    <= ThrW'(5120);
      cfg_q.consistent_count <= CountW'(2);
      cfg_q.cooldown_samples <= CycW'(15);
      cfg_q.timeout_samples  <= CycW'(100);
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        RegZThresh:       cfg_q.z_thresh         <= cfg_data_i[ThrW-1:0];
        RegMinMagnitude:  cfg_q.min_magnitude    <= cfg_data_i[ThrW-1:0];
        RegExtremeLimit:  cfg_q.extreme_limit    <= cfg_data_i[ThrW-1:0];
        RegConsistentCnt: cfg_q.consistent_count <= cfg_data_i[CountW-1:0];
        RegCooldownSmp:   cfg_q.cooldown_samples <= cfg_data_i[CycW-1:0];
        RegTimeoutSmp:    cfg_q.timeout_samples  <= cfg_data_i[CycW-1:0];
        default: ;
      endcase
    end
  end

  ard_feature u_feature (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .accel_x_i     (accel_x_i),
    .accel_y_i     (accel_y_i),
    .accel_z_i     (accel_z_i),
    .flags_valid_o (flags_valid),
    .flags_ready_i (flags_ready),
    .flags_o       (flags)
  );

  assign flags_ready = !out_valid_q || out_ready_i;

  always_comb begin
    in_rep_d  = in_rep_q;
    down_d    = down_q;
    up_d      = up_q;
    cool_d    = cool_q;
    timer_d   = timer_q;
    det_d     = 1'b0;
    done      = 1'b0;
    cnt_inc   = '0;
    timer_inc = '0;
    if (flags.extreme) begin
      det_d = 1'b0;
    end else if (cool_q != '0) begin
      cool_d = cool_q - 1'b1;
    end else if (!in_rep_q) begin
      if (flags.z_low && flags.mag_ok) begin
        cnt_inc = (down_q == CountMax) ? down_q : down_q + 1'b1;
        down_d  = cnt_inc;
        if (cnt_inc >= cfg_q.consistent_count) begin
          in_rep_d = 1'b1;
          down_d   = '0;
          timer_d  = '0;
        end
      end else if (down_q != '0) begin
        down_d = down_q - 1'b1;
      end
    end else begin
      if (flags.z_high && flags.mag_ok) begin
        cnt_inc = (up_q == CountMax) ? up_q : up_q + 1'b1;
        up_d    = cnt_inc;
        if (cnt_inc >= cfg_q.consistent_count) begin
          in_rep_d = 1'b0;
          up_d     = '0;
          timer_d  = '0;
          cool_d   = cfg_q.cooldown_samples;
          det_d    = 1'b1;
          done     = 1'b1;
        end
      end else if (up_q != '0) begin
        up_d = up_q - 1'b1;
      end
      if (!done) begin
        timer_inc = (timer_q == CycMax) ? timer_q : timer_q + 1'b1;
        timer_d   = timer_inc;
        if (timer_inc > cfg_q.timeout_samples) begin
          in_rep_d = 1'b0;
          timer_d  = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_rep_q    <= 1'b0;
      down_q      <= '0;
      up_q        <= '0;
      cool_q      <= '0;
      timer_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (flags_ready) begin
        out_valid_q <= flags_valid;
      end
      if (flags_ready && flags_valid) begin
        in_rep_q <= in_rep_d;
        down_q   <= down_d;
        up_q     <= up_d;
        cool_q   <= cool_d;
        timer_q  <= timer_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (flags_ready && flags_valid) begin
      det_q  <= det_d;
      prog_q <= in_rep_d;
      ign_q  <= flags.extreme;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign rep_detected_o    = det_q;
  assign rep_in_progress_o = prog_q;
  assign sample_ignored_o  = ign_q;

endmodule

[design/ard_checker.sv]
// Port-level checker for the accelerometer repetition detector, bound to the top level.
// Depends on ard_pkg and accel_rep_detector.
module ard_checker import ard_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic in_ready_o,
  input logic out_valid_o,
  input logic out_ready_i,
  input logic rep_detected_o,
  input logic rep_in_progress_o,
  input logic sample_ignored_o
);

  // A stalled result holds until it is transferred.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(rep_detected_o)
      && $stable(rep_in_progress_o) && $stable(sample_ignored_o))
    else $error("stalled result changed before its transfer");

  // Completing a rep ends it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && rep_detected_o |-> !rep_in_progress_o)
    else $error("rep reported as complete and in progress");

  // An ignored sample never completes a rep.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && sample_ignored_o |-> !rep_detected_o)
    else $error("ignored sample completed a rep");

  // With no result waiting, the pipeline must be able to take a sample.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with an empty result register");

endmodule

bind accel_rep_detector ard_checker u_ard_checker (.*);

[test/accel_rep_detector_tb.sv]
// Self-checking testbench for accel_rep_detector: random valid/ready traffic on the sample and
// result channels, with every result checked against a behavioural rep tracker kept in step with
// accepted samples. Depends on ard_pkg and the design files only.
`timescale 1ns / 100ps

module accel_rep_detector_tb;
  import ard_pkg::*;

  localparam int StallLimit = 2000;
  localparam int HoldCycles = 120;
  localparam logic [CfgIdxW-1:0] UnusedRegIdx = 3'd6;

  typedef struct packed {
    logic signed [SampleBits-1:0] x;
    logic signed [SampleBits-1:0] y;
    logic signed [SampleBits-1:0] z;
  } accel_sample_t;

  typedef struct packed {
    logic detected;
    logic in_progress;
    logic ignored;
  } rep_flags_t;

  typedef enum int {SwingDown, SwingUp, SwingIdle, SwingNoise, SwingEdge} swing_e;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         in_valid_i = 1'b0;
  logic                         in_ready_o;
  logic signed [SampleBits-1:0] accel_x_i = '0;
  logic signed [SampleBits-1:0] accel_y_i = '0;
  logic signed [SampleBits-1:0] accel_z_i = '0;
  logic                         out_valid_o;
  logic                         out_ready_i = 1'b0;
  logic                         rep_detected_o;
  logic                         rep_in_progress_o;
  logic                         sample_ignored_o;
  logic                         cfg_valid_i = 1'b0;
  logic                         cfg_ready_o;
  logic [CfgIdxW-1:0]           cfg_index_i = '0;
  logic [CfgDataW-1:0]          cfg_data_i = '0;

  accel_rep_detector i_dut (.*);

  // Register settings and rep state as the tracker sees them.
  ard_cfg_t          cfg_now = '{z_thresh: 15'd77, min_magnitude: 15'd256,
                                 extreme_limit: 15'd5120, consistent_count: 4'd2,
                                 cooldown_samples: 8'd15, timeout_samples: 8'd100};
  logic              in_rep = 1'b0;
  logic [CountW-1:0] down_cnt = '0;
  logic [CountW-1:0] up_cnt = '0;
  logic [CycW-1:0]   cooldown_left = '0;
  logic [CycW-1:0]   rep_age = '0;

  accel_sample_t pending_samples[$];
  rep_flags_t    awaited_flags[$];
  int samples_queued = 0;
  int samples_offered = 0;
  int samples_taken = 0;
  int cfg_writes = 0;
  int mismatches = 0;
  int quiet_cycles = 0;
  int sender_idle_pct = 30;
  int rx_idle_pct = 30;
  int rx_hold_requests = 0;
  int rx_holds_started = 0;
  int rx_hold_left = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic rep_flags_t track_rep(accel_sample_t s);
    longint sx, sy, sz, az, mag_sq, lim, floor_mag, thr;
    logic mag_ok;
    rep_flags_t r;
    sx = s.x;
    sy = s.y;
    sz = s.z;
    az = (sz < 0) ? -sz : sz;
    mag_sq = sx * sx + sy * sy + sz * sz;
    lim = longint'(cfg_now.extreme_limit);
    floor_mag = longint'(cfg_now.min_magnitude);
    thr = longint'(cfg_now.z_thresh);
    r = '0;
    if (az > lim || mag_sq > lim * lim) begin
      r.ignored = 1'b1;
      r.in_progress = in_rep;
      return r;
    end
    mag_ok = mag_sq > floor_mag * floor_mag;
    if (cooldown_left != 0) begin
      cooldown_left--;
    end else if (!in_rep) begin
      if (sz < -thr && mag_ok) begin
        if (down_cnt != CountMax) down_cnt++;
        if (down_cnt >= cfg_now.consistent_count) begin
          in_rep = 1'b1;
          down_cnt = '0;
          rep_age = '0;
        end
      end else if (down_cnt != 0) begin
        down_cnt--;
      end
    end else begin
      if (sz > thr && mag_ok) begin
        if (up_cnt != CountMax) up_cnt++;
        if (up_cnt >= cfg_now.consistent_count) begin
          in_rep = 1'b0;
          up_cnt = '0;
          rep_age = '0;
          cooldown_left = cfg_now.cooldown_samples;
          r.detected = 1'b1;
        end
      end else if (up_cnt != 0) begin
        up_cnt--;
      end
      if (!r.detected) begin
        if (rep_age != CycMax) rep_age++;
        if (rep_age > cfg_now.timeout_samples) begin
          in_rep = 1'b0;
          rep_age = '0;
        end
      end
    end
    r.in_progress = in_rep;
    return r;
  endfunction

  // Transfers seen at the rising edge: register writes, accepted samples and results.
  always @(posedge clk_i) begin
    rep_flags_t want;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_reg_e'(cfg_index_i))
          RegZThresh:       cfg_now.z_thresh = cfg_data_i[ThrW-1:0];
          RegMinMagnitude:  cfg_now.min_magnitude = cfg_data_i[ThrW-1:0];
          RegExtremeLimit:  cfg_now.extreme_limit = cfg_data_i[ThrW-1:0];
          RegConsistentCnt: cfg_now.consistent_count = cfg_data_i[CountW-1:0];
          RegCooldownSmp:   cfg_now.cooldown_samples = cfg_data_i[CycW-1:0];
          RegTimeoutSmp:    cfg_now.timeout_samples = cfg_data_i[CycW-1:0];
          default: ;
        endcase
        cfg_writes <= cfg_writes + 1;
      end
      if (out_valid_o && out_ready_i) begin
        if (awaited_flags.size() == 0) begin
          $display("%0t: unexpected result: detected %0b in_progress %0b ignored %0b", $time,
                   rep_detected_o, rep_in_progress_o, sample_ignored_o);
          mismatches++;
        end else begin
          want = awaited_flags.pop_front();
          if (rep_detected_o !== want.detected) begin
            $display("%0t: rep_detected expected %0b, got %0b", $time, want.detected,
                     rep_detected_o);
            mismatches++;
          end
          if (rep_in_progress_o !== want.in_progress) begin
            $display("%0t: rep_in_progress expected %0b, got %0b", $time, want.in_progress,
                     rep_in_progress_o);
            mismatches++;
          end
          if (sample_ignored_o !== want.ignored) begin
            $display("%0t: sample_ignored expected %0b, got %0b", $time, want.ignored,
                     sample_ignored_o);
            mismatches++;
          end
        end
      end
      if (in_valid_i && in_ready_o) begin
        awaited_flags.push_back(track_rep('{x: accel_x_i, y: accel_y_i, z: accel_z_i}));
        samples_taken <= samples_taken + 1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles < StallLimit) begin
      quiet_cycles <= quiet_cycles + 1;
    end else begin
      $display("%0t: no transfer for %0d cycles", $time, StallLimit);
      $display("** accel_rep_detector: FAILED **");
      $finish;
    end
  end

  // Sample driver: holds an offered sample until its transfer, otherwise idles at random.
  always @(negedge clk_i) begin
    accel_sample_t s;
    if (rst_ni && !(in_valid_i && samples_taken < samples_offered)) begin
      if (pending_samples.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
        s = pending_samples.pop_front();
        in_valid_i <= 1'b1;
        accel_x_i <= s.x;
        accel_y_i <= s.y;
        accel_z_i <= s.z;
        samples_offered++;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (rx_hold_left > 0) begin
      out_ready_i <= 1'b0;
      rx_hold_left <= rx_hold_left - 1;
    end else if (rx_holds_started < rx_hold_requests) begin
      out_ready_i <= 1'b0;
      rx_hold_left <= HoldCycles;
      rx_holds_started <= rx_holds_started + 1;
    end else begin
      out_ready_i <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  task automatic queue_sample(accel_sample_t s);
    pending_samples.push_back(s);
    samples_queued++;
  endtask

  task automatic queue_xyz(int x, int y, int z);
    queue_sample('{x: x[SampleBits-1:0], y: y[SampleBits-1:0], z: z[SampleBits-1:0]});
  endtask

  function automatic accel_sample_t make_sample(swing_e kind);
    accel_sample_t s;
    int thr, lim, lo, hi, mag, v;
    thr = int'(cfg_now.z_thresh);
    lim = int'(cfg_now.extreme_limit);
    lo = (thr + 1 > int'(cfg_now.min_magnitude)) ? thr + 1 : int'(cfg_now.min_magnitude) + 1;
    if (lo > 32767) lo = 32767;
    hi = (lim < lo) ? lo : lim;
    mag = $urandom_range(hi, lo);
    v = int'($urandom_range(128)) - 64;
    s.x = v[SampleBits-1:0];
    v = int'($urandom_range(128)) - 64;
    s.y = v[SampleBits-1:0];
    case (kind)
      SwingDown: v = -mag;
      SwingUp:   v = mag;
      SwingIdle: v = int'($urandom_range(2 * thr)) - thr;
      SwingNoise: begin
        s.x = SampleBits'($urandom);
        s.y = SampleBits'($urandom);
        v = $urandom;
      end
      default: begin
        case ($urandom_range(5))
          0: v = thr;
          1: v = -thr;
          2: v = thr + 1;
          3: v = -thr - 1;
          4: v = lim;
          default: v = -lim - 1;
        endcase
      end
    endcase
    s.z = v[SampleBits-1:0];
    return s;
  endfunction

  // Mostly whole reps (start, hold, finish, cooldown) with random content, the rest noise or edges.
  task automatic run_random_phase(int count);
    int goal, n, cool_cap;
    goal = samples_queued + count;
    while (samples_queued < goal) begin
      if ($urandom_range(99) < 70) begin
        n = int'(cfg_now.consistent_count) + $urandom_range(2);
        cool_cap = (cfg_now.cooldown_samples > 20) ? 20 : int'(cfg_now.cooldown_samples);
        repeat (n) queue_sample(make_sample(SwingDown));
        repeat ($urandom_range(($urandom_range(3) == 0) ? 40 : 8)) begin
          queue_sample(make_sample(($urandom_range(5) == 0) ? SwingNoise : SwingIdle));
        end
        repeat (n) queue_sample(make_sample(SwingUp));
        repeat ($urandom_range(cool_cap)) queue_sample(make_sample(SwingIdle));
      end else begin
        queue_sample(make_sample(($urandom_range(1) == 0) ? SwingNoise : SwingEdge));
      end
    end
  endtask

  task automatic wait_drained();
    while (pending_samples.size() != 0 || samples_taken != samples_queued ||
           awaited_flags.size() != 0) begin
      @(negedge clk_i);
    end
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, int value, int width);
    int target;
    logic [31:0] word;
    word = ($urandom << width) | (value & ((1 << width) - 1));
    target = cfg_writes + 1;
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= word[CfgDataW-1:0];
    do @(negedge clk_i); while (cfg_writes != target);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic load_settings(int thr, int floor_mag, int lim, int cnt, int cool, int tmo);
    wait_drained();
    write_reg(RegZThresh, thr, ThrW);
    write_reg(RegMinMagnitude, floor_mag, ThrW);
    write_reg(RegExtremeLimit, lim, ThrW);
    write_reg(RegConsistentCnt, cnt, CountW);
    write_reg(RegCooldownSmp, cool, CycW);
    write_reg(RegTimeoutSmp, tmo, CycW);
  endtask

  initial begin
    int k;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: extremes of the axes, the limit edges, one full rep and its cooldown.
    queue_xyz(32767, 32767, 32767);
    queue_xyz(-32768, -32768, -32768);
    queue_xyz(0, 0, 0);
    queue_xyz(0, 0, 5120);
    queue_xyz(0, 0, -5121);
    queue_xyz(5121, 0, 0);
    queue_xyz(3000, 3000, 3000);
    queue_xyz(-3620, -3620, 0);
    queue_xyz(0, 0, -512);
    queue_xyz(0, 0, -200);
    queue_xyz(0, 0, -512);
    queue_xyz(-1, -1, -512);
    queue_xyz(0, 0, -32768);
    queue_xyz(0, 0, 512);
    queue_xyz(0, 0, 77);
    queue_xyz(0, 0, 512);
    queue_xyz(0, 0, 512);
    queue_xyz(0, 0, -512);
    queue_xyz(0, 0, -512);
    queue_xyz(32767, -32768, 0);

    // A single reading starts or ends a rep, no cooldown, and a one-sample timeout.
    load_settings(77, 256, 5120, 0, 0, 1);
    write_reg(UnusedRegIdx, $urandom, CfgDataW);
    queue_xyz(0, 0, -512);
    queue_xyz(0, 0, 0);
    queue_xyz(0, 0, 0);
    queue_xyz(0, 0, -512);
    queue_xyz(0, 0, 512);
    queue_xyz(0, 0, -512);
    run_random_phase(30);

    // With a timeout of 255 a rep outlives the saturated timer.
    load_settings(0, 0, 32767, 1, 255, 255);
    queue_xyz(-1, -1, -1);
    repeat (270) queue_xyz(0, 0, 0);
    queue_xyz(0, 0, 1);
    run_random_phase(20);

    load_settings(32767, 32767, 0, 15, 0, 254);
    queue_xyz(0, 0, 0);
    run_random_phase(20);

    for (k = 0; k < 6; k++) begin
      if (k == 3) begin
        load_settings($urandom_range(32767), $urandom_range(32767), $urandom_range(32767),
                      $urandom_range(15), $urandom_range(255), $urandom_range(255));
      end else begin
        load_settings($urandom_range(600), $urandom_range(400), $urandom_range(32767, 800),
                      $urandom_range(($urandom_range(3) == 0) ? 15 : 4), $urandom_range(8),
                      $urandom_range(60, 1));
      end
      sender_idle_pct = (k == 1 || k == 2) ? 0 : 30;
      rx_idle_pct = (k == 1) ? 0 : 30;
      if (k == 2) rx_hold_requests++;
      run_random_phase(50);
    end

    wait_drained();
    repeat (20) @(negedge clk_i);
    if (mismatches == 0 && awaited_flags.size() == 0) begin
      $display("** accel_rep_detector: PASSED **");
    end else begin
      $display("** accel_rep_detector: FAILED **");
    end
    $finish;
  end

endmodule

[sim.f]
design/ard_pkg.sv
design/ard_feature.sv
design/accel_rep_detector.sv
design/ard_checker.sv
test/accel_rep_detector_tb.sv
